[hw/rtl/dpa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpa_pkg
// Shared widths, constants and codes of the dipole potential accumulator.
// ----------------------------------------------------------------------------
package dpa_pkg;

  localparam int FLD_W     = 32;   // coordinate, moment, scale, conductivity
  localparam int POT_W     = 48;   // potential, Q15.32
  localparam int Q_BITS    = 50;   // increment magnitude clamps at 2^Q_BITS
  localparam int NUM_SHIFT = 92;   // numerator alignment of the quotient
  localparam int CFG_IDX_W = 3;

  // 4*pi in Q4.28
  localparam logic [FLD_W-1:0] FOUR_PI_Q28 = 32'd3373259426;

  localparam logic signed [POT_W-1:0] POT_MAX = {1'b0, {(POT_W-1){1'b1}}};
  localparam logic signed [POT_W-1:0] POT_MIN = {1'b1, {(POT_W-1){1'b0}}};

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_SAT   = 2'd1;
  localparam status_t ST_ZSIG  = 2'd2;
  localparam status_t ST_ZDIST = 2'd3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_DIPOLE_X = 3'd0;
  localparam cfg_idx_t REG_DIPOLE_Y = 3'd1;
  localparam cfg_idx_t REG_DIPOLE_Z = 3'd2;
  localparam cfg_idx_t REG_MOMENT_X = 3'd3;
  localparam cfg_idx_t REG_MOMENT_Y = 3'd4;
  localparam cfg_idx_t REG_MOMENT_Z = 3'd5;
  localparam cfg_idx_t REG_SCALE    = 3'd6;

  localparam logic [FLD_W-1:0] SCALE_RESET = 32'd65536;

endpackage

[hw/rtl/dpa_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpa_if
// Channels of the accumulator: node words in, potential words out, config.
// ----------------------------------------------------------------------------

// node word: position, conductivity, running potential
interface dpa_node_if import dpa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [FLD_W-1:0] node_x;
  logic [FLD_W-1:0] node_y;
  logic [FLD_W-1:0] node_z;
  logic [FLD_W-1:0] conductivity;
  logic [POT_W-1:0] potential_in;

  modport source (output valid, node_x, node_y, node_z, conductivity, potential_in,
                  input ready);
  modport sink   (input valid, node_x, node_y, node_z, conductivity, potential_in,
                  output ready);
endinterface

// result word: updated potential and status
interface dpa_pot_if import dpa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POT_W-1:0] potential_out;
  status_t          status;

  modport source (output valid, potential_out, status, input ready);
  modport sink   (input valid, potential_out, status, output ready);
endinterface

// register write channel
interface dpa_cfg_if import dpa_pkg::*; ();
  logic             valid;
  logic             ready;
  cfg_idx_t         index;
  logic [FLD_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/dpa_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpa_mul
// Pipelined unsigned multiplier: one digit of b per stage, side word rides along.
// ----------------------------------------------------------------------------
module dpa_mul #(
  parameter int AW = 32,
  parameter int BW = 32,
  parameter int NS = 2,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          v_i,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  input  logic [SW-1:0] side_i,
  output logic          v_o,
  output logic [AW+BW-1:0] p,
  output logic [SW-1:0] side_o
);

  localparam int DG = (BW + NS - 1) / NS;
  localparam int BP = DG * NS;
  localparam int PW = AW + BP;

  logic [PW-1:0] acc [NS];
  logic [AW-1:0] ar  [NS];
  logic [BP-1:0] br  [NS];
  logic [SW-1:0] sr  [NS];
  logic [NS-1:0] vr;
  logic [BP-1:0] b_pad;

  assign b_pad = BP'(b);

  for (genvar i = 0; i < NS; i++) begin : g_st
    logic [PW-1:0]    acc_in;
    logic [AW-1:0]    a_in;
    logic [BP-1:0]    b_in;
    logic [SW-1:0]    s_in;
    logic             v_in;
    logic [AW+DG-1:0] pp;

    if (i == 0) begin : g_in
      assign acc_in = '0;
      assign a_in   = a;
      assign b_in   = b_pad;
      assign s_in   = side_i;
      assign v_in   = v_i;
    end else begin : g_chain
      assign acc_in = acc[i-1];
      assign a_in   = ar[i-1];
      assign b_in   = br[i-1];
      assign s_in   = sr[i-1];
      assign v_in   = vr[i-1];
    end

    // partial product of this digit
    assign pp = a_in * b_in[i*DG +: DG];

    always_ff @(posedge clk) begin
      if (en) begin
        acc[i] <= acc_in + (PW'(pp) << (i * DG));
        ar[i]  <= a_in;
        br[i]  <= b_in;
        sr[i]  <= s_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vr[i] <= 1'b0;
      end else if (en) begin
        vr[i] <= v_in;
      end
    end
  end

  assign p      = acc[NS-1][AW+BW-1:0];
  assign side_o = sr[NS-1];
  assign v_o    = vr[NS-1];

endmodule

[hw/rtl/dpa_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpa_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module dpa_sqrt #(
  parameter int RW = 49,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            v_i,
  input  logic [2*RW-1:0] x,
  input  logic [SW-1:0]   side_i,
  output logic            v_o,
  output logic [RW-1:0]   root,
  output logic [SW-1:0]   side_o
);

  logic [RW+1:0]   rem [RW];
  logic [RW-1:0]   rt  [RW];
  logic [2*RW-1:0] xr  [RW];
  logic [SW-1:0]   sr  [RW];
  logic [RW-1:0]   vr;

  for (genvar i = 0; i < RW; i++) begin : g_st
    logic [RW+1:0]   rem_in;
    logic [RW-1:0]   rt_in;
    logic [2*RW-1:0] x_in;
    logic [SW-1:0]   s_in;
    logic            v_in;
    logic [RW+1:0]   cur;
    logic [RW+1:0]   trial;
    logic            ge;

    if (i == 0) begin : g_in
      assign rem_in = '0;
      assign rt_in  = '0;
      assign x_in   = x;
      assign s_in   = side_i;
      assign v_in   = v_i;
    end else begin : g_chain
      assign rem_in = rem[i-1];
      assign rt_in  = rt[i-1];
      assign x_in   = xr[i-1];
      assign s_in   = sr[i-1];
      assign v_in   = vr[i-1];
    end

    // bring down two bits, try root*4+1
    assign cur   = {rem_in[RW-1:0], x_in[2*RW-1 -: 2]};
    assign trial = {rt_in, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? cur - trial : cur;
        rt[i]  <= {rt_in[RW-2:0], ge};
        xr[i]  <= x_in << 2;
        sr[i]  <= s_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vr[i] <= 1'b0;
      end else if (en) begin
        vr[i] <= v_in;
      end
    end
  end

  assign root   = rt[RW-1];
  assign side_o = sr[RW-1];
  assign v_o    = vr[RW-1];

endmodule

[hw/rtl/dpa_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpa_div
// Pipelined restoring divider with a clamped quotient of QB+1 bits.
// ----------------------------------------------------------------------------
module dpa_div #(
  parameter int NW   = 190,
  parameter int DENW = 179,
  parameter int QB   = 50,
  parameter int SW   = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            v_i,
  input  logic [NW-1:0]   num,
  input  logic [DENW-1:0] den,
  input  logic [SW-1:0]   side_i,
  output logic            v_o,
  output logic [QB:0]     q,
  output logic [SW-1:0]   side_o
);

  localparam int ZW = (NW > DENW + QB + 1) ? NW : DENW + QB + 1;
  localparam int NST = QB + 1;

  logic [ZW-1:0]   rem [NST];
  logic [DENW-1:0] dr  [NST];
  logic [QB-1:0]   qr  [NST];
  logic [NST-1:0]  sat;
  logic [SW-1:0]   sr  [NST];
  logic [NST-1:0]  vr;

  for (genvar j = 0; j < NST; j++) begin : g_st
    localparam int K = QB - j;
    logic [ZW-1:0]   rem_in;
    logic [DENW-1:0] d_in;
    logic [QB-1:0]   q_in;
    logic            sat_in;
    logic [SW-1:0]   s_in;
    logic            v_in;
    logic [ZW-1:0]   dsh;
    logic            ge;
    logic [ZW-1:0]   rem_n;
    logic [QB-1:0]   q_n;
    logic            sat_n;

    if (j == 0) begin : g_in
      assign rem_in = ZW'(num);
      assign d_in   = den;
      assign q_in   = '0;
      assign sat_in = 1'b0;
      assign s_in   = side_i;
      assign v_in   = v_i;
    end else begin : g_chain
      assign rem_in = rem[j-1];
      assign d_in   = dr[j-1];
      assign q_in   = qr[j-1];
      assign sat_in = sat[j-1];
      assign s_in   = sr[j-1];
      assign v_in   = vr[j-1];
    end

    assign dsh = ZW'(d_in) << K;
    assign ge  = rem_in >= dsh;

    // top stage only detects the clamp; the rest produce quotient bits
    if (j == 0) begin : g_clamp
      assign rem_n = rem_in;
      assign q_n   = q_in;
      assign sat_n = ge;
    end else begin : g_bit
      always_comb begin
        rem_n    = (ge && !sat_in) ? rem_in - dsh : rem_in;
        q_n      = q_in;
        q_n[K]   = ge && !sat_in;
      end
      assign sat_n = sat_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= rem_n;
        dr[j]  <= d_in;
        qr[j]  <= q_n;
        sat[j] <= sat_n;
        sr[j]  <= s_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vr[j] <= 1'b0;
      end else if (en) begin
        vr[j] <= v_in;
      end
    end
  end

  assign q      = sat[NST-1] ? {1'b1, {QB{1'b0}}} : {1'b0, qr[NST-1]};
  assign side_o = sr[NST-1];
  assign v_o    = vr[NST-1];

endmodule

[hw/rtl/dipole_potential_accumulate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dipole_potential_accumulate
// Adds the infinite-medium dipole potential to each node's running potential.
// Pipeline depth is set mainly by the one-bit-per-stage square root and the 51-stage divider.
// Throughput: one word per cycle; a stalled output freezes the whole pipeline.
// Reset: synchronous; clears all stage valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module dipole_potential_accumulate import dpa_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  dpa_node_if.sink  node,
  dpa_pot_if.source result,
  dpa_cfg_if.sink   cfg
);

  localparam int CW   = COORD_WIDTH;
  localparam int SQW  = 2 * CW;
  localparam int DSW  = SQW + 2;          // |R|^2
  localparam int PRW  = FLD_W + CW;       // |p_k|*|R_k|
  localparam int DMW  = PRW + 2;          // |p.R|
  localparam int RW   = (DSW + 32 + 1) / 2;
  localparam int NS_A = (CW + 15) / 16;
  localparam int NS_X = 4;
  localparam int NS_Y = 8;
  localparam int DSPW = DSW + RW;         // |R|^2 * |R|
  localparam int CSW  = 2 * FLD_W;        // 4pi * sigma
  localparam int DENW = DSPW + CSW;
  localparam int NMW  = DMW + FLD_W;      // |scale| * |p.R|
  localparam int NW   = NMW + NUM_SHIFT;
  localparam int SA   = 2 + FLD_W + POT_W;
  localparam int SB   = 1 + DMW + DSW + 2 + FLD_W + POT_W;
  localparam int SX   = 1 + 2 + POT_W;
  localparam int SY   = NMW + SX;

  function automatic logic [CW-1:0] to_coord(input logic [FLD_W-1:0] v);
    logic [CW+FLD_W-1:0] z;
    z = {{CW{1'b0}}, v};
    return z[CW-1:0];
  endfunction

  // configuration registers
  logic [FLD_W-1:0] dip   [3];
  logic [FLD_W-1:0] mom   [3];
  logic [FLD_W-1:0] scale;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dip[0] <= '0;
      dip[1] <= '0;
      dip[2] <= '0;
      mom[0] <= '0;
      mom[1] <= '0;
      mom[2] <= '0;
      scale  <= SCALE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DIPOLE_X: dip[0] <= cfg.data;
        REG_DIPOLE_Y: dip[1] <= cfg.data;
        REG_DIPOLE_Z: dip[2] <= cfg.data;
        REG_MOMENT_X: mom[0] <= cfg.data;
        REG_MOMENT_Y: mom[1] <= cfg.data;
        REG_MOMENT_Z: mom[2] <= cfg.data;
        REG_SCALE:    scale  <= cfg.data;
        default: ;
      endcase
    end
  end

  // global advance: the output register is free or being emptied
  logic out_valid;
  logic en;

  assign en         = !out_valid || result.ready;
  assign node.ready = en;

  // static config terms
  logic             sc_neg;
  logic [FLD_W-1:0] sc_mag;
  logic [FLD_W-1:0] p_mag [3];

  assign sc_neg = scale[FLD_W-1];
  assign sc_mag = sc_neg ? ~scale + 1'b1 : scale;

  // stage 0: displacement R = node - dipole
  logic [FLD_W-1:0]     node_c [3];
  logic signed [CW:0]   rdiff  [3];
  logic signed [CW:0]   rabs   [3];
  logic                 rzero;
  logic                 v0;
  logic [CW-1:0]        rmag0  [3];
  logic [2:0]           tneg0;
  status_t              spec0;
  logic [FLD_W-1:0]     sig0;
  logic [POT_W-1:0]     pin0;

  assign node_c[0] = node.node_x;
  assign node_c[1] = node.node_y;
  assign node_c[2] = node.node_z;

  for (genvar k = 0; k < 3; k++) begin : g_r
    logic [CW-1:0] nc;
    logic [CW-1:0] dc;
    assign nc       = to_coord(node_c[k]);
    assign dc       = to_coord(dip[k]);
    assign rdiff[k] = $signed({nc[CW-1], nc}) - $signed({dc[CW-1], dc});
    assign rabs[k]  = rdiff[k][CW] ? -rdiff[k] : rdiff[k];
    assign p_mag[k] = mom[k][FLD_W-1] ? ~mom[k] + 1'b1 : mom[k];
  end

  assign rzero = (rdiff[0] == '0) && (rdiff[1] == '0) && (rdiff[2] == '0);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        rmag0[k] <= rabs[k][CW-1:0];
        tneg0[k] <= rdiff[k][CW] ^ mom[k][FLD_W-1];
      end
      sig0  <= node.conductivity;
      pin0  <= node.potential_in;
      if (node.conductivity == '0) begin
        spec0 <= ST_ZSIG;
      end else if (rzero) begin
        spec0 <= ST_ZDIST;
      end else begin
        spec0 <= ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= node.valid;
    end
  end

  // squares and moment products per axis
  logic [SQW-1:0] sq     [3];
  logic [PRW-1:0] pr     [3];
  logic [SA-1:0]  sa_o   [3];
  logic [2:0]     tneg_a;
  logic [2:0]     va;

  for (genvar k = 0; k < 3; k++) begin : g_ax
    dpa_mul #(.AW(CW), .BW(CW), .NS(NS_A), .SW(SA)) u_sq (
      .clk(clk), .rst(rst), .en(en), .v_i(v0),
      .a(rmag0[k]), .b(rmag0[k]), .side_i({spec0, sig0, pin0}),
      .v_o(va[k]), .p(sq[k]), .side_o(sa_o[k])
    );
    dpa_mul #(.AW(FLD_W), .BW(CW), .NS(NS_A), .SW(1)) u_pr (
      .clk(clk), .rst(rst), .en(en), .v_i(v0),
      .a(p_mag[k]), .b(rmag0[k]), .side_i(tneg0[k]),
      .v_o(), .p(pr[k]), .side_o(tneg_a[k])
    );
  end

  // stage 2: |R|^2 and signed dot product
  logic signed [DMW:0] term [3];
  logic signed [DMW:0] dot;
  logic                v2;
  logic [DSW-1:0]      d2;
  logic [DMW-1:0]      dmag2;
  logic                dneg2;
  status_t             spec2;
  logic [FLD_W-1:0]    sig2;
  logic [POT_W-1:0]    pin2;

  for (genvar k = 0; k < 3; k++) begin : g_term
    assign term[k] = tneg_a[k] ? -$signed({3'b000, pr[k]}) : $signed({3'b000, pr[k]});
  end

  assign dot = term[0] + term[1] + term[2];

  always_ff @(posedge clk) begin
    if (en) begin
      d2    <= DSW'(sq[0]) + DSW'(sq[1]) + DSW'(sq[2]);
      dneg2 <= dot[DMW];
      dmag2 <= dot[DMW] ? DMW'(-dot) : DMW'(dot);
      {spec2, sig2, pin2} <= sa_o[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= va[0];
    end
  end

  // |R| in Q.16 relative to the coordinate scale
  logic             vs;
  logic [RW-1:0]    root;
  logic             dneg_s;
  logic [DMW-1:0]   dmag_s;
  logic [DSW-1:0]   d_s;
  status_t          spec_s;
  logic [FLD_W-1:0] sig_s;
  logic [POT_W-1:0] pin_s;
  logic [SB-1:0]    sb_o;

  dpa_sqrt #(.RW(RW), .SW(SB)) u_sqrt (
    .clk(clk), .rst(rst), .en(en), .v_i(v2),
    .x((2*RW)'({d2, 32'd0})),
    .side_i({dneg2, dmag2, d2, spec2, sig2, pin2}),
    .v_o(vs), .root(root), .side_o(sb_o)
  );

  assign {dneg_s, dmag_s, d_s, spec_s, sig_s, pin_s} = sb_o;

  // first product rank
  logic            vx;
  logic [DSPW-1:0] ds_x;
  logic [CSW-1:0]  cs_x;
  logic [NMW-1:0]  nm_x;
  logic [SX-1:0]   sx_o;

  dpa_mul #(.AW(DSW), .BW(RW), .NS(NS_X), .SW(SX)) u_ds (
    .clk(clk), .rst(rst), .en(en), .v_i(vs),
    .a(d_s), .b(root), .side_i({dneg_s, spec_s, pin_s}),
    .v_o(vx), .p(ds_x), .side_o(sx_o)
  );

  dpa_mul #(.AW(FLD_W), .BW(FLD_W), .NS(NS_X), .SW(1)) u_cs (
    .clk(clk), .rst(rst), .en(en), .v_i(vs),
    .a(sig_s), .b(FOUR_PI_Q28), .side_i(1'b0),
    .v_o(), .p(cs_x), .side_o()
  );

  dpa_mul #(.AW(DMW), .BW(FLD_W), .NS(NS_X), .SW(1)) u_nm (
    .clk(clk), .rst(rst), .en(en), .v_i(vs),
    .a(dmag_s), .b(sc_mag), .side_i(1'b0),
    .v_o(), .p(nm_x), .side_o()
  );

  // full denominator
  logic            vy;
  logic [DENW-1:0] den_y;
  logic [NMW-1:0]  nm_y;
  logic [SX-1:0]   sx_y;

  dpa_mul #(.AW(DSPW), .BW(CSW), .NS(NS_Y), .SW(SY)) u_den (
    .clk(clk), .rst(rst), .en(en), .v_i(vx),
    .a(ds_x), .b(cs_x), .side_i({nm_x, sx_o}),
    .v_o(vy), .p(den_y), .side_o({nm_y, sx_y})
  );

  // clamped quotient
  logic             vd;
  logic [Q_BITS:0]  qd;
  logic             dneg_d;
  status_t          spec_d;
  logic [POT_W-1:0] pin_d;

  dpa_div #(.NW(NW), .DENW(DENW), .QB(Q_BITS), .SW(SX)) u_div (
    .clk(clk), .rst(rst), .en(en), .v_i(vy),
    .num({nm_y, {NUM_SHIFT{1'b0}}}), .den(den_y), .side_i(sx_y),
    .v_o(vd), .q(qd), .side_o({dneg_d, spec_d, pin_d})
  );

  // final add with saturation
  logic signed [POT_W+3:0] pin_e;
  logic signed [POT_W+3:0] inc_e;
  logic signed [POT_W+3:0] total;
  logic [POT_W-1:0]        pot_next;
  status_t                 status_next;

  assign pin_e = {{4{pin_d[POT_W-1]}}, pin_d};
  assign inc_e = (dneg_d ^ sc_neg) ? -$signed((POT_W+4)'(qd)) : $signed((POT_W+4)'(qd));
  assign total = pin_e + inc_e;

  always_comb begin
    pot_next    = pin_d;
    status_next = spec_d;
    if (spec_d == ST_OK) begin
      if (total > $signed({{4{1'b0}}, POT_MAX})) begin
        pot_next    = POT_MAX;
        status_next = ST_SAT;
      end else if (total < $signed({{4{1'b1}}, POT_MIN})) begin
        pot_next    = POT_MIN;
        status_next = ST_SAT;
      end else begin
        pot_next    = total[POT_W-1:0];
      end
    end
  end

  // output register
  logic [POT_W-1:0] pot_out;
  status_t          status_out;

  always_ff @(posedge clk) begin
    if (en) begin
      pot_out    <= pot_next;
      status_out <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vd;
    end
  end

  assign result.valid         = out_valid;
  assign result.potential_out = pot_out;
  assign result.status        = status_out;

endmodule

[hw/rtl/dpa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpa_checker
// Port-level assertions for the dipole potential accumulator.
// ----------------------------------------------------------------------------
module dpa_checker import dpa_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             node_valid,
  input logic             node_ready,
  input logic             result_valid,
  input logic             result_ready,
  input logic [POT_W-1:0] potential_out,
  input status_t          status
);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result word valid right after reset");

  // a waiting word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(potential_out) && $stable(status))
    else $error("stalled result word changed");

  // pipeline freezes while the output waits
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !node_ready)
    else $error("node word taken while output stalled");

  // saturation lands exactly on a bound
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == ST_SAT) |->
      ($signed(potential_out) == POT_MAX) || ($signed(potential_out) == POT_MIN))
    else $error("saturated word not at a bound");

endmodule

bind dipole_potential_accumulate dpa_checker u_dpa_checker (
  .clk           (clk),
  .rst           (rst),
  .node_valid    (node.valid),
  .node_ready    (node.ready),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .potential_out (result.potential_out),
  .status        (result.status)
);
